FILE: rtl/work_break_interval_timer_top_defines.svh
// assertion macros for the timer rtl
`ifndef WORK_BREAK_INTERVAL_TIMER_TOP_DEFINES_SVH
`define WORK_BREAK_INTERVAL_TIMER_TOP_DEFINES_SVH

// checked only outside reset
`define WBIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WBIT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/wbit_pkg.sv
// types and constants for the work/break interval timer
package wbit_pkg;

    localparam int WORK_BITS     = 24;
    localparam int BREAK_BITS    = 24;
    localparam int STEP_BITS     = 16;
    localparam int ELAPSED_BITS  = 32;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [WORK_BITS-1:0]  WORK_LEN_RESET  = 24'd1500000;
    localparam logic [BREAK_BITS-1:0] BREAK_LEN_RESET = 24'd300000;
    localparam logic [STEP_BITS-1:0]  MAX_STEP_RESET  = 16'd1000;

    localparam logic [CFG_IDX_BITS-1:0] REG_WORK_LEN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BREAK_LEN = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_STEP  = 2'd2;

    localparam logic PHASE_WORK  = 1'b0;
    localparam logic PHASE_BREAK = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TOGGLE = 2'd1,
        KIND_RESET  = 2'd2,
        KIND_REINIT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_PAUSE = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORK_BITS-1:0]  work_len;
        logic [BREAK_BITS-1:0] break_len;
        logic [STEP_BITS-1:0]  max_step;
    } t_cfg;

endpackage

FILE: rtl/wbit_cfg.sv
// configuration registers of the interval timer
module wbit_cfg
    import wbit_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.work_len  <= WORK_LEN_RESET;
            r_cfg.break_len <= BREAK_LEN_RESET;
            r_cfg.max_step  <= MAX_STEP_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WORK_LEN:  r_cfg.work_len  <= i_cfg_data[WORK_BITS-1:0];
                REG_BREAK_LEN: r_cfg.break_len <= i_cfg_data[BREAK_BITS-1:0];
                REG_MAX_STEP:  r_cfg.max_step  <= i_cfg_data[STEP_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/wbit_core.sv
// timer state registers and per-command next-state logic
`include "work_break_interval_timer_top_defines.svh"

module wbit_core
    import wbit_pkg::*;
#(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [1:0]              i_kind,
    input  logic [ELAPSED_BITS-1:0] i_elapsed_ms,
    input  t_cfg                    i_cfg,
    output logic                    o_finished,
    output logic                    o_phase,
    output logic [1:0]              o_status,
    output logic [TIME_BITS-1:0]    o_left,
    output logic [TIME_BITS-1:0]    o_length,
    output logic [COUNT_BITS-1:0]   o_done
);

    logic                  r_finished, n_finished;
    logic                  r_phase,    n_phase;
    t_status               r_status,   n_status;
    logic [TIME_BITS-1:0]  r_left,     n_left;
    logic [TIME_BITS-1:0]  r_length,   n_length;
    logic [COUNT_BITS-1:0] r_done,     n_done;

    logic [STEP_BITS-1:0]  dt;
    logic [TIME_BITS-1:0]  dt_ext;
    logic                  ends;

    // clamp the elapsed time to the max step
    assign dt     = (i_elapsed_ms > ELAPSED_BITS'(i_cfg.max_step))
                    ? i_cfg.max_step : i_elapsed_ms[STEP_BITS-1:0];
    assign dt_ext = TIME_BITS'(dt);
    assign ends   = (dt_ext >= r_left);

    always_comb begin
        n_finished = 1'b0;
        n_phase    = r_phase;
        n_status   = r_status;
        n_left     = r_left;
        n_length   = r_length;
        n_done     = r_done;
        case (t_kind'(i_kind))
            KIND_TICK: begin
                if (r_status == ST_RUN) begin
                    if (!ends) begin
                        n_left = r_left - dt_ext;
                    end else begin
                        n_finished = 1'b1;
                        if (r_phase == PHASE_WORK) begin
                            n_done   = r_done + COUNT_BITS'(1);
                            n_phase  = PHASE_BREAK;
                            n_length = TIME_BITS'(i_cfg.break_len);
                            n_left   = TIME_BITS'(i_cfg.break_len);
                        end else begin
                            n_phase  = PHASE_WORK;
                            n_length = TIME_BITS'(i_cfg.work_len);
                            n_left   = TIME_BITS'(i_cfg.work_len);
                        end
                    end
                end
            end
            KIND_TOGGLE: begin
                n_status = (r_status == ST_RUN) ? ST_PAUSE : ST_RUN;
            end
            KIND_RESET: begin
                n_left = r_length;
                if (r_status != ST_IDLE) begin
                    n_status = ST_PAUSE;
                end
            end
            KIND_REINIT: begin
                n_phase  = PHASE_WORK;
                n_status = ST_IDLE;
                n_length = TIME_BITS'(i_cfg.work_len);
                n_left   = TIME_BITS'(i_cfg.work_len);
                n_done   = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished <= 1'b0;
            r_phase    <= PHASE_WORK;
            r_status   <= ST_IDLE;
            r_left     <= TIME_BITS'(WORK_LEN_RESET);
            r_length   <= TIME_BITS'(WORK_LEN_RESET);
            r_done     <= '0;
        end else if (i_fire) begin
            r_finished <= n_finished;
            r_phase    <= n_phase;
            r_status   <= n_status;
            r_left     <= n_left;
            r_length   <= n_length;
            r_done     <= n_done;
        end
    end

    assign o_finished = r_finished;
    assign o_phase    = r_phase;
    assign o_status   = r_status;
    assign o_left     = r_left;
    assign o_length   = r_length;
    assign o_done     = r_done;

    // a finished phase has just been reloaded in full and keeps running
    `WBIT_ASSERT_ALWAYS(a_finish_reload, r_finished |-> (r_left == r_length), "finish without reload")
    `WBIT_ASSERT_ALWAYS(a_finish_runs, r_finished |-> (r_status == ST_RUN), "finish while not running")
    // state only moves when a request is processed
    `WBIT_ASSERT(a_hold_idle, !i_fire |=> $stable({r_phase, r_status, r_left, r_length, r_done}), "state moved without request")

endmodule

FILE: rtl/work_break_interval_timer_top.sv
// Work/break interval timer: each command request (tick, toggle, reset phase,
// reinitialise) produces one result holding a phase-finished flag and a snapshot
// of the timer state after the command. One command is taken every clock cycle
// while the output does not stall; a result is valid once its request has gone
// from the input register into the state register, also the result register.
// While a result waits on a stalled output the state holds, so the input register
// takes one more request and then stalls until the result is taken.
// Configuration writes take effect on the next command and are always ready.
module work_break_interval_timer_top
    import wbit_pkg::*;
#(
    parameter int TIME_BITS  = 24,
    parameter int COUNT_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic [ELAPSED_BITS-1:0]  i_elapsed_ms,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_phase_finished,
    output logic                     o_phase_now,
    output logic [1:0]               o_run_status,
    output logic [TIME_BITS-1:0]     o_time_left_ms,
    output logic [TIME_BITS-1:0]     o_phase_length_ms,
    output logic [COUNT_BITS-1:0]    o_work_done_count
);

    t_cfg                    cfg;
    logic                    r_in_valid;
    logic [1:0]              r_kind;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic                    r_out_valid;
    logic                    out_free;
    logic                    fire;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind    <= i_kind;
            r_elapsed <= i_elapsed_ms;
        end
    end

    wbit_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wbit_core #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_kind),
        .i_elapsed_ms (r_elapsed),
        .i_cfg        (cfg),
        .o_finished   (o_phase_finished),
        .o_phase      (o_phase_now),
        .o_status     (o_run_status),
        .o_left       (o_time_left_ms),
        .o_length     (o_phase_length_ms),
        .o_done       (o_work_done_count)
    );

endmodule

FILE: sim/tb_work_break_interval_timer_top.sv
// testbench for the work/break interval timer: directed and random commands checked against a predictor
`timescale 1ns / 100ps

module tb_work_break_interval_timer_top;
    import wbit_pkg::*;

    // register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic        finished;
        logic        phase;
        logic [1:0]  status;
        logic [23:0] left;
        logic [23:0] length;
        logic [15:0] done;
    } t_timer_snapshot;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [31:0] i_elapsed_ms;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_phase_finished;
    logic        o_phase_now;
    logic [1:0]  o_run_status;
    logic [23:0] o_time_left_ms;
    logic [23:0] o_phase_length_ms;
    logic [15:0] o_work_done_count;

    // timer state as the predictor sees it
    logic [23:0] cfg_work_len;
    logic [23:0] cfg_break_len;
    logic [15:0] cfg_max_step;
    logic        tmr_phase;
    t_status     tmr_status;
    logic [23:0] tmr_left;
    logic [23:0] tmr_length;
    logic [15:0] tmr_done;

    t_timer_snapshot expected_snapshots[$];
    t_timer_snapshot want;
    bit          gaps_on;
    int          error_count;
    int          commands_sent;
    int          phase_ends;
    int          reg_writes;
    int          snapshots_checked;

    work_break_interval_timer_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_elapsed_ms      (i_elapsed_ms),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phase_finished  (o_phase_finished),
        .o_phase_now       (o_phase_now),
        .o_run_status      (o_run_status),
        .o_time_left_ms    (o_time_left_ms),
        .o_phase_length_ms (o_phase_length_ms),
        .o_work_done_count (o_work_done_count)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(0, 99) < 28);
    end

    task automatic reload_timer();
        tmr_phase  = PHASE_WORK;
        tmr_status = ST_IDLE;
        tmr_length = cfg_work_len;
        tmr_left   = cfg_work_len;
        tmr_done   = '0;
    endtask

    task automatic predict_command(input t_kind kind, input logic [31:0] elapsed);
        t_timer_snapshot snap;
        logic [31:0]     dt;
        snap.finished = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (tmr_status == ST_RUN) begin
                    dt = elapsed;
                    if (dt > {16'd0, cfg_max_step})
                        dt = {16'd0, cfg_max_step};
                    if (dt < {8'd0, tmr_left}) begin
                        tmr_left = tmr_left - dt[23:0];
                    end else begin
                        snap.finished = 1'b1;
                        if (tmr_phase == PHASE_WORK) begin
                            tmr_done   = tmr_done + 16'd1;
                            tmr_phase  = PHASE_BREAK;
                            tmr_length = cfg_break_len;
                        end else begin
                            tmr_phase  = PHASE_WORK;
                            tmr_length = cfg_work_len;
                        end
                        tmr_left = tmr_length;
                        phase_ends++;
                    end
                end
            end
            KIND_TOGGLE: tmr_status = (tmr_status == ST_RUN) ? ST_PAUSE : ST_RUN;
            KIND_RESET: begin
                tmr_left = tmr_length;
                if (tmr_status != ST_IDLE)
                    tmr_status = ST_PAUSE;
            end
            default: reload_timer();
        endcase
        snap.phase  = tmr_phase;
        snap.status = tmr_status;
        snap.left   = tmr_left;
        snap.length = tmr_length;
        snap.done   = tmr_done;
        expected_snapshots.push_back(snap);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_command(input t_kind kind, input logic [31:0] elapsed);
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_elapsed_ms <= elapsed;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_command(kind, elapsed);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_snapshots();
        i_in_valid <= 1'b0;
        while (expected_snapshots.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // only while nothing is in flight
    task automatic write_register(input logic [1:0] index, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (index)
            REG_WORK_LEN:  cfg_work_len  = data;
            REG_BREAK_LEN: cfg_break_len = data;
            REG_MAX_STEP:  cfg_max_step  = data[15:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [23:0] exp_val,
                               input logic [23:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_snapshots.size() == 0) begin
                $display("%0t: result with no request pending, expected none got left %0d",
                         $time, o_time_left_ms);
                error_count++;
            end else begin
                want = expected_snapshots.pop_front();
                check_field("phase_finished", 24'(want.finished), 24'(o_phase_finished));
                check_field("phase_now", 24'(want.phase), 24'(o_phase_now));
                check_field("run_status", 24'(want.status), 24'(o_run_status));
                check_field("time_left_ms", want.left, o_time_left_ms);
                check_field("phase_length_ms", want.length, o_phase_length_ms);
                check_field("work_done_count", 24'(want.done), 24'(o_work_done_count));
                snapshots_checked++;
            end
        end
    end

    task automatic test_reset_defaults();
        send_command(KIND_TICK, 32'hFFFF_FFFF);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_TICK, 32'h0);
        send_command(KIND_TICK, 32'hFFFF_FFFF);
        send_command(KIND_TICK, 32'd999);
        send_command(KIND_RESET, 32'h0);
        send_command(KIND_TICK, 32'd5);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_REINIT, 32'h0);
        send_command(KIND_RESET, 32'h0);
        wait_for_snapshots();
    endtask

    // zero lengths end a phase on any running tick, zero step applies nothing
    task automatic test_zero_settings();
        write_register(REG_WORK_LEN, 24'd0);
        write_register(REG_BREAK_LEN, 24'd0);
        write_register(REG_MAX_STEP, 24'd0);
        write_register(REG_UNUSED, 24'hFFFFFF);
        send_command(KIND_REINIT, 32'h0);
        send_command(KIND_TICK, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_TICK, 32'h0);
        send_command(KIND_TICK, 32'd12345);
        send_command(KIND_RESET, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        wait_for_snapshots();
    endtask

    task automatic test_extremes();
        write_register(REG_WORK_LEN, 24'hFFFFFF);
        write_register(REG_BREAK_LEN, 24'd1);
        write_register(REG_MAX_STEP, 24'hFFFFFF);   // upper bits dropped
        send_command(KIND_REINIT, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_TICK, 32'hFFFF_FFFF);
        send_command(KIND_TICK, 32'hAAAA_AAAA);
        send_command(KIND_TICK, 32'h5555_5555);
        wait_for_snapshots();
        write_register(REG_WORK_LEN, 24'd2);
        write_register(REG_BREAK_LEN, 24'hFFFFFF);
        send_command(KIND_REINIT, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        send_command(KIND_TICK, 32'd2);
        send_command(KIND_TICK, 32'hFFFF_FFFF);
        wait_for_snapshots();
    endtask

    // a phase ends on every tick, back to back with no idling on either side
    task automatic test_back_to_back_ends();
        gaps_on = 1'b0;
        write_register(REG_WORK_LEN, 24'd0);
        write_register(REG_BREAK_LEN, 24'd0);
        write_register(REG_MAX_STEP, 24'd1);
        send_command(KIND_REINIT, 32'h0);
        send_command(KIND_TOGGLE, 32'h0);
        for (int n = 0; n < 16; n++)
            send_command(KIND_TICK, $urandom);
        wait_for_snapshots();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int          pick;
        int          top_len;
        logic [31:0] elapsed;
        for (int round = 0; round < 5; round++) begin
            top_len = (round == 1) ? 3 : 40;
            gaps_on = (round != 3);
            write_register(REG_WORK_LEN, 24'($urandom_range(1, top_len)));
            write_register(REG_BREAK_LEN, 24'($urandom_range(0, top_len)));
            write_register(REG_MAX_STEP, 24'((round == 1) ? $urandom_range(0, 3) :
                                                            $urandom_range(1, 20)));
            send_command(KIND_REINIT, 32'h0);
            send_command(KIND_TOGGLE, 32'h0);
            for (int n = 0; n < 100; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_command(KIND_TOGGLE, $urandom);
                end else if (pick < 16) begin
                    send_command(KIND_RESET, $urandom);
                end else if (pick < 19) begin
                    send_command(KIND_REINIT, $urandom);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 15)
                        elapsed = $urandom;
                    else if (pick < 60)
                        elapsed = $urandom_range(0, cfg_max_step + 2);
                    else
                        elapsed = $urandom_range(0, 8);
                    send_command(KIND_TICK, elapsed);
                end
                // hold off until the pipe is empty now and then
                if (n == 50)
                    wait_for_snapshots();
            end
            wait_for_snapshots();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_WORK_LEN;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_TICK;
        i_elapsed_ms = '0;
        i_out_stall  = 1'b0;
        gaps_on      = 1'b1;
        error_count  = 0;
        commands_sent = 0;
        phase_ends   = 0;
        reg_writes   = 0;
        snapshots_checked = 0;
        cfg_work_len  = WORK_LEN_RESET;
        cfg_break_len = BREAK_LEN_RESET;
        cfg_max_step  = MAX_STEP_RESET;
        reload_timer();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_zero_settings();
        test_extremes();
        test_random_traffic();
        test_back_to_back_ends();

        wait_for_snapshots();
        repeat (10) @(negedge i_clk);
        $display("ran %0d commands and %0d register writes, %0d phase ends seen;",
                 commands_sent, reg_writes, phase_ends);
        $display("checked %0d snapshots incl. zero and full-range settings and back to back ends",
                 snapshots_checked);
        if (error_count == 0 && expected_snapshots.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_snapshots.size());
        $display("Verification failed");
        $finish;
    end

endmodule
